FILE: hw/rtl/ftkc_pkg.sv
// Shared types and constants for the FIFO tile key cache.
package ftkc_pkg;

  // Width of the entry count and of the capacity register.
  localparam int COUNT_W = 5;
  localparam int KEY_W = 53;
  localparam int HANDLE_W = 16;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0]          func;
    logic [4:0]          zoom_level;
    logic [23:0]         tile_col;
    logic [23:0]         tile_row;
    logic [HANDLE_W-1:0] payload_handle;
  } req_t;

  // One result item.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_step;
    logic evict_read;
    logic evict_take;
    logic write_entry;
    logic clear;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       scan_done;
    logic       out_free;
  } status_t;

endpackage

FILE: hw/rtl/fifo_tile_key_cache.sv
// Top level of the FIFO tile key cache.
//
// A fully associative store of tile keys (zoom, column, row) with a 16-bit
// handle each, replaced first in, first out. Requests arrive on the in_*
// channel (lookup, insert or clear) and every request yields exactly one
// result on the out_* channel. The capacity register is written through the
// cfg_* channel, which is always ready; write it only while no request is open.
//
// Timing: a request is taken in the idle state, decoded in the dispatch state
// that follows, and its result is registered once its work ends. A lookup
// reads one entry per cycle through the single read port of the entry memory
// and stops at the first match or after the last stored entry. An insert
// writes the new entry, first reading and dropping the oldest one when the
// store is full; a clear empties the store, an unused code changes nothing.
// One request is worked on at a time; the next is taken while the previous
// result waits in the output register. If the receiver stalls, a finished
// request waits until the output register frees up.
//
// Reset (synchronous, active high) empties the store and sets the capacity to
// 16. The entry memories are not cleared; the fill count guards their reads.
module fifo_tile_key_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ftkc_pkg::req_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ftkc_pkg::rsp_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ftkc_pkg::COUNT_W-1:0] cfg_data
);

  ftkc_pkg::cmd_t    cmd;
  ftkc_pkg::status_t status;

  // Sequencer.
  ftkc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and result path.
  ftkc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: hw/rtl/ftkc_datapath.sv
// Datapath of the tile key cache: entry memories, pointers, scan logic and result register.
module ftkc_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ftkc_pkg::req_t                 in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ftkc_pkg::COUNT_W-1:0]   cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ftkc_pkg::rsp_t                 out_data,
  input  ftkc_pkg::cmd_t                 cmd,
  output ftkc_pkg::status_t              status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = ((IW > ftkc_pkg::COUNT_W) ? IW : ftkc_pkg::COUNT_W) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [SW-1:0] DEPTH = SW'(ENTRIES);
  localparam logic [ftkc_pkg::COUNT_W-1:0] CAP_MAX =
    (ENTRIES > 31) ? 5'd31 : ftkc_pkg::COUNT_W'(ENTRIES);
  localparam logic [ftkc_pkg::COUNT_W-1:0] CAP_RESET = 5'd16;

  // Entry storage.
  logic [ftkc_pkg::KEY_W-1:0]    key_mem [ENTRIES];
  logic [ftkc_pkg::HANDLE_W-1:0] handle_mem [ENTRIES];

  logic [ftkc_pkg::COUNT_W-1:0]  capacity;
  logic [ftkc_pkg::COUNT_W-1:0]  eff_cap;
  logic [ftkc_pkg::COUNT_W-1:0]  count;
  logic [IW-1:0]                 oldest;
  logic [IW-1:0]                 scan_ptr;
  logic [ftkc_pkg::COUNT_W-1:0]  remaining;
  logic                          rd_pending;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  logic [ftkc_pkg::KEY_W-1:0]    key_q;
  logic [ftkc_pkg::HANDLE_W-1:0] handle_q;
  ftkc_pkg::req_t                req_q;
  logic [ftkc_pkg::KEY_W-1:0]    req_key;
  logic                          match;
  logic [SW-1:0]                 tail_sum;
  logic [IW-1:0]                 wr_addr;
  logic                          hit_r;
  logic [ftkc_pkg::HANDLE_W-1:0] found_r;
  logic                          ev_r;
  logic [ftkc_pkg::HANDLE_W-1:0] evh_r;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // The configuration register is always ready for a transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Capacity clamped to the range the store supports.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = 5'd1;
    end else if (capacity > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = capacity;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= in_data;
    end
  end

  assign req_key = {req_q.zoom_level, req_q.tile_col, req_q.tile_row};

  // Position just past the newest entry, wrapped into the store.
  always_comb begin
    tail_sum = SW'(oldest) + SW'(count);
    if (tail_sum >= DEPTH) begin
      tail_sum = tail_sum - DEPTH;
    end
  end
  assign wr_addr = tail_sum[IW-1:0];

  // Shared read port: the scan walks from the oldest entry, eviction reads the oldest.
  assign rd_en   = (cmd.scan_step && (remaining != '0)) || cmd.evict_read;
  assign rd_addr = cmd.evict_read ? oldest : scan_ptr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_q    <= key_mem[rd_addr];
      handle_q <= handle_mem[rd_addr];
    end
    if (cmd.write_entry) begin
      key_mem[wr_addr]    <= req_key;
      handle_mem[wr_addr] <= req_q.payload_handle;
    end
  end

  assign match = rd_pending && (key_q == req_key);

  // Scan pointer, remaining entries and read pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      remaining  <= '0;
      scan_ptr   <= '0;
    end else if (cmd.load) begin
      rd_pending <= 1'b0;
      remaining  <= count;
      scan_ptr   <= oldest;
    end else if (cmd.scan_step) begin
      rd_pending <= (remaining != '0);
      if (remaining != '0) begin
        remaining <= remaining - 1'b1;
        scan_ptr  <= ptr_inc(scan_ptr);
      end
    end
  end

  // Oldest position and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (cmd.clear) begin
      oldest <= '0;
      count  <= '0;
    end else if (cmd.evict_take) begin
      oldest <= ptr_inc(oldest);
      count  <= count - 1'b1;
    end else if (cmd.write_entry) begin
      count <= count + 1'b1;
    end
  end

  // Result fields gathered while the item is worked on.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r   <= 1'b0;
      found_r <= '0;
      ev_r    <= 1'b0;
      evh_r   <= '0;
    end else begin
      if (cmd.scan_step && match) begin
        hit_r   <= 1'b1;
        found_r <= handle_q;
      end
      if (cmd.evict_take) begin
        ev_r  <= 1'b1;
        evh_r <= handle_q;
      end
    end
  end

  // Output register: holds a finished result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.hit            <= hit_r;
      out_data.found_handle   <= found_r;
      out_data.evicted        <= ev_r;
      out_data.evicted_handle <= evh_r;
      out_data.entry_count    <= count;
    end
  end

  // Status back to the controller.
  assign status.func      = req_q.func;
  assign status.full      = (count >= eff_cap);
  assign status.scan_done = match || ((remaining == '0) && !rd_pending);
  assign status.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(count) <= ENTRIES))
    else $error("entry count exceeds the store depth");
  a_oldest_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(oldest) < ENTRIES))
    else $error("oldest position outside the store");
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over a waiting result");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0) && (oldest == '0))
    else $error("clear left entries behind");
`endif

endmodule

FILE: hw/rtl/ftkc_ctrl.sv
// Controller state machine that sequences lookup, insert and clear operations.
module ftkc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftkc_pkg::status_t status,
  output ftkc_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_DISPATCH   = 7'b0000010,
    S_SCAN       = 7'b0000100,
    S_EVICT_RD   = 7'b0001000,
    S_EVICT_TAKE = 7'b0010000,
    S_WRITE      = 7'b0100000,
    S_RESULT     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.func)
          ftkc_pkg::FUNC_LOOKUP: state_next = S_SCAN;
          ftkc_pkg::FUNC_INSERT: state_next = status.full ? S_EVICT_RD : S_WRITE;
          ftkc_pkg::FUNC_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_RESULT;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = S_RESULT;
        end
      end
      S_EVICT_RD: begin
        cmd.evict_read = 1'b1;
        state_next     = S_EVICT_TAKE;
      end
      S_EVICT_TAKE: begin
        cmd.evict_take = 1'b1;
        state_next     = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
